### design/cdq_pkg.sv
// Package for the circular double-ended queue unit.
// Holds request and status codes, widths and the control struct for the cell chains.
// No dependencies.
package cdq_pkg;

  localparam int DATA_W        = 32;
  localparam int REQ_W         = 3;
  localparam int STATUS_W      = 2;
  localparam int DEPTH_DEFAULT = 8;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_REAR   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PEEK_FRONT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_PEEK_REAR  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic              shift_up;
    logic              shift_down;
    logic              write_end;
    logic [DATA_W-1:0] value;
  } chain_ctl_t;

endpackage

### design/cdq_cell.sv
// Deque chain cell: holds a word, loads it from a neighbour or the push value.
// Depends on cdq_pkg.
module cdq_cell #(
  parameter int CNT_W = 4,
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  cdq_pkg::chain_ctl_t       ctl,
  input  logic [CNT_W-1:0]          cnt,
  input  logic [cdq_pkg::DATA_W-1:0] d_lower,
  input  logic [cdq_pkg::DATA_W-1:0] d_upper,
  output logic [cdq_pkg::DATA_W-1:0] q
);

  localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

  always_ff @(posedge clk) begin
    if (ctl.write_end && (cnt == MY_INDEX)) begin
      q <= ctl.value;
    end else if (ctl.shift_up) begin
      q <= d_lower;
    end else if (ctl.shift_down) begin
      q <= d_upper;
    end
  end

endmodule

### design/cdq_chain.sv
// Row of DEPTH cells, head at cell 0, shifting up or down as one.
// Depends on cdq_pkg and cdq_cell.
module cdq_chain #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                       clk,
  input  cdq_pkg::chain_ctl_t        ctl,
  input  logic [CNT_W-1:0]           cnt,
  output logic [cdq_pkg::DATA_W-1:0] head
);

  logic [cdq_pkg::DATA_W-1:0] q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [cdq_pkg::DATA_W-1:0] lower;
    logic [cdq_pkg::DATA_W-1:0] upper;

    if (i == 0) begin : g_first
      assign lower = ctl.value;
    end else begin : g_mid_lo
      assign lower = q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = q[i];
    end else begin : g_mid_hi
      assign upper = q[i+1];
    end

    cdq_cell #(
      .CNT_W (CNT_W),
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .cnt     (cnt),
      .d_lower (lower),
      .d_upper (upper),
      .q       (q[i])
    );
  end

  assign head = q[0];

endmodule

### design/circular_double_ended_queue_unit.sv
// Top level of the circular double-ended queue unit.
// Depends on cdq_pkg and cdq_chain (two chains: front-aligned and rear-aligned).
//
//  channel  dir  handshake          payload
//  s_       in   s_tvalid/s_tready  s_tuser: req_type | s_tdata: push_value
//  m_       out  m_tvalid/m_tready  m_tuser: status   | m_tdata: read_value
//
// One transaction per cycle when not stalled; chains and output register load together.
// A push shifts one chain and writes the other at the fill count; a pop shifts one chain.
// Reset clears the fill count and the output valid; cell contents stay undefined.
// A stalled result holds the output register; a new request is taken as it drains.
module circular_double_ended_queue_unit #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [cdq_pkg::DATA_W-1:0]   s_tdata,  // [31:0] push_value
  input  logic [cdq_pkg::REQ_W-1:0]    s_tuser,  // [2:0] req_type
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cdq_pkg::DATA_W-1:0]   m_tdata,  // [31:0] read_value
  output logic [cdq_pkg::STATUS_W-1:0] m_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            cnt_next;
  logic                        accept;
  logic                        full;
  logic                        empty;
  cdq_pkg::chain_ctl_t         ctl_a;
  cdq_pkg::chain_ctl_t         ctl_b;
  logic [cdq_pkg::DATA_W-1:0]  a_head;
  logic [cdq_pkg::DATA_W-1:0]  b_head;
  logic [cdq_pkg::STATUS_W-1:0] status_next;
  logic [cdq_pkg::DATA_W-1:0]  data_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign full     = (cnt == CNT_FULL);
  assign empty    = (cnt == '0);

  always_comb begin
    ctl_a       = '0;
    ctl_b       = '0;
    ctl_a.value = s_tdata;
    ctl_b.value = s_tdata;
    cnt_next    = cnt;
    status_next = cdq_pkg::ST_DONE;
    data_next   = '0;
    if (accept) begin
      case (s_tuser)
        cdq_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            status_next = cdq_pkg::ST_FULL;
          end else begin
            ctl_a.shift_up  = 1'b1;
            ctl_b.write_end = 1'b1;
            cnt_next        = cnt + CNT_ONE;
          end
        end
        cdq_pkg::REQ_PUSH_REAR: begin
          if (full) begin
            status_next = cdq_pkg::ST_FULL;
          end else begin
            ctl_b.shift_up  = 1'b1;
            ctl_a.write_end = 1'b1;
            cnt_next        = cnt + CNT_ONE;
          end
        end
        cdq_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            status_next = cdq_pkg::ST_EMPTY;
          end else begin
            data_next        = a_head;
            ctl_a.shift_down = 1'b1;
            cnt_next         = cnt - CNT_ONE;
          end
        end
        cdq_pkg::REQ_POP_REAR: begin
          if (empty) begin
            status_next = cdq_pkg::ST_EMPTY;
          end else begin
            data_next        = b_head;
            ctl_b.shift_down = 1'b1;
            cnt_next         = cnt - CNT_ONE;
          end
        end
        cdq_pkg::REQ_PEEK_FRONT: begin
          if (empty) begin
            status_next = cdq_pkg::ST_EMPTY;
          end else begin
            data_next = a_head;
          end
        end
        cdq_pkg::REQ_PEEK_REAR: begin
          if (empty) begin
            status_next = cdq_pkg::ST_EMPTY;
          end else begin
            data_next = b_head;
          end
        end
        default: begin
        end
      endcase
    end
  end

  cdq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_front_chain (
    .clk  (clk),
    .ctl  (ctl_a),
    .cnt  (cnt),
    .head (a_head)
  );

  cdq_chain #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_rear_chain (
    .clk  (clk),
    .ctl  (ctl_b),
    .cnt  (cnt),
    .head (b_head)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= data_next;
      m_tuser <= status_next;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL)
    else $error("fill count beyond depth");

  a_single_heads: assert property (@(posedge clk) disable iff (rst)
    (cnt == CNT_ONE) |-> (a_head == b_head))
    else $error("front and rear chains disagree on the only element");

  a_full_refuse: assert property (@(posedge clk) disable iff (rst)
    (accept && full && (s_tuser == cdq_pkg::REQ_PUSH_FRONT ||
                        s_tuser == cdq_pkg::REQ_PUSH_REAR))
    |=> (m_tuser == cdq_pkg::ST_FULL) && (cnt == $past(cnt)))
    else $error("push into full queue not refused");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    (accept && !empty && (s_tuser == cdq_pkg::REQ_POP_FRONT ||
                          s_tuser == cdq_pkg::REQ_POP_REAR))
    |=> (cnt == $past(cnt) - CNT_ONE) && (m_tuser == cdq_pkg::ST_DONE))
    else $error("pop did not drop one element");

endmodule
